// ===== design/bqd_pkg.sv =====
// Shared types, constants and helpers for the biquad DF2T section.
// No dependencies; used by bqd_lane, the core and the checker.
package bqd_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 32;

    // Integer bits of the sample (Q4.F) and coefficient (Q6.G) formats
    localparam int SAMPLE_INT_W = 4;
    localparam int COEF_INT_W   = 6;

    // Delay accumulators are Q10.46
    localparam int ACC_W    = 56;
    localparam int ACC_FRAC = 46;

    // Aligned product: sign plus magnitude limited to 2^62
    localparam int ALN_W = 64;
    // Sum width that holds two aligned products plus an accumulator
    localparam int SUM_W = 66;

    // Serial multiplier digit: radix 4
    localparam int DIGIT_W = 2;

    // Coefficient register file
    localparam int NUM_COEFS = 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } coef_idx_t;

    // Section sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_SUM_Y,
        ST_ROUND,
        ST_EMIT,
        ST_MUL_FB,
        ST_DIFF,
        ST_UPDATE
    } core_state_t;

    // Multiplier lane sequencer
    typedef enum logic [1:0] {
        LN_IDLE,
        LN_STEP,
        LN_ALIGN,
        LN_SIGN
    } lane_state_t;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

    // Saturate a wide sum to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[ACC_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bqd_lane.sv =====
// Radix-4 serial-parallel multiplier lane: |op| x |coef| two bits per cycle,
// then round/align to Q.46, limit to 2^62 and apply the sign. Uses bqd_pkg.
module bqd_lane #(
    parameter int OP_W   = bqd_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAG_W  = bqd_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_W = bqd_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_W = bqd_pkg::ACC_FRAC
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [OP_W-1:0]            op,
    input  logic signed [COEF_W-1:0]          coef,
    output logic                              done,
    output logic signed [bqd_pkg::ALN_W-1:0]  product
);

    localparam int NUM_DIG = (MAG_W + bqd_pkg::DIGIT_W - 1) / bqd_pkg::DIGIT_W;
    localparam int PAD_W   = NUM_DIG * bqd_pkg::DIGIT_W;
    localparam int CNT_W   = $clog2(NUM_DIG);
    localparam int PROD_W  = COEF_W + PAD_W;
    localparam int STEP_W  = COEF_W + bqd_pkg::DIGIT_W;
    localparam int MAGO_W  = bqd_pkg::ALN_W - 1;
    localparam int SHR     = (FRAC_W > bqd_pkg::ACC_FRAC) ? FRAC_W - bqd_pkg::ACC_FRAC : 0;
    localparam int SHL     = (FRAC_W < bqd_pkg::ACC_FRAC) ? bqd_pkg::ACC_FRAC - FRAC_W : 0;
    localparam int EXT_RAW = PROD_W + 1 + SHL;
    localparam int EXT_W   = (EXT_RAW > bqd_pkg::ALN_W) ? EXT_RAW : bqd_pkg::ALN_W;
    localparam int HALF_POS = (SHR > 0) ? SHR - 1 : 0;
    localparam logic HALF_ON = (SHR > 0);
    localparam logic [EXT_W-1:0] HALF    = HALF_ON ? (EXT_W'(1) << HALF_POS) : '0;
    localparam logic [EXT_W-1:0] MAG_LIM = EXT_W'(1) << (bqd_pkg::ALN_W - 2);
    localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(NUM_DIG - 1);

    bqd_pkg::lane_state_t state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [COEF_W-1:0]    hi_reg;
    logic [PAD_W-1:0]     lo_reg;
    logic [COEF_W-1:0]    cmag_reg;
    logic                 neg_reg;
    logic [MAGO_W-1:0]    mag_reg;
    logic signed [bqd_pkg::ALN_W-1:0] product_reg;

    logic [OP_W-1:0]      op_abs;
    logic [COEF_W-1:0]    coef_abs;
    logic [STEP_W-1:0]    step_sum;
    logic [EXT_W-1:0]     ext;
    logic [MAGO_W-1:0]    mag_next;
    logic signed [bqd_pkg::ALN_W-1:0] pos;

    // operand magnitudes
    assign op_abs   = op[OP_W-1] ? OP_W'(-op) : OP_W'(op);
    assign coef_abs = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);

    // one radix-4 digit: hi + d0*C + d1*2C
    assign step_sum = STEP_W'(hi_reg)
                    + (lo_reg[0] ? STEP_W'(cmag_reg) : '0)
                    + (lo_reg[1] ? (STEP_W'(cmag_reg) << 1) : '0);

    // align to Q.46, round half away from zero on the magnitude, limit to 2^62
    assign ext      = ((EXT_W'({hi_reg, lo_reg}) + HALF) >> SHR) << SHL;
    assign mag_next = (ext > MAG_LIM) ? MAG_LIM[MAGO_W-1:0] : ext[MAGO_W-1:0];
    assign pos      = signed'({1'b0, mag_reg});

    // lane sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            bqd_pkg::LN_IDLE: begin
                if (start) begin
                    cnt_next   = '0;
                    state_next = bqd_pkg::LN_STEP;
                end
            end
            bqd_pkg::LN_STEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIG) begin
                    state_next = bqd_pkg::LN_ALIGN;
                end
            end
            bqd_pkg::LN_ALIGN: begin
                state_next = bqd_pkg::LN_SIGN;
            end
            bqd_pkg::LN_SIGN: begin
                done_next  = 1'b1;
                state_next = bqd_pkg::LN_IDLE;
            end
            default: begin
                state_next = bqd_pkg::LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bqd_pkg::LN_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == bqd_pkg::LN_IDLE && start) begin
            lo_reg   <= PAD_W'(op_abs[MAG_W-1:0]);
            hi_reg   <= '0;
            cmag_reg <= coef_abs;
            neg_reg  <= op[OP_W-1] ^ coef[COEF_W-1];
        end
        if (state_reg == bqd_pkg::LN_STEP) begin
            hi_reg <= step_sum[STEP_W-1:bqd_pkg::DIGIT_W];
            lo_reg <= {step_sum[bqd_pkg::DIGIT_W-1:0], lo_reg[PAD_W-1:bqd_pkg::DIGIT_W]};
        end
        if (state_reg == bqd_pkg::LN_ALIGN) begin
            mag_reg <= mag_next;
        end
        if (state_reg == bqd_pkg::LN_SIGN) begin
            product_reg <= neg_reg ? -pos : pos;
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

// ===== design/biquad_df2t_section_core.sv =====
// A result word is loaded into the output register from ST_EMIT, after the input lanes and
// the ST_SUM_Y and ST_ROUND states. A new word is taken only in ST_IDLE, after the radix-4
// multiplier lanes have run twice in series (input, then feedback) and the delays are updated.
// A waiting result word holds the section only when the next result is ready to load.
// Reset (aresetn low, synchronous): delays cleared, b0 = 1.0, other coefficients 0,
// no result pending. Uses bqd_pkg and bqd_lane.
module biquad_df2t_section_core #(
    parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqd_pkg::COEF_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_sample_out,
    output logic                              m_clamped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_WIDTH-1:0]             cfg_data
);

    localparam int ACC_W  = bqd_pkg::ACC_W;
    localparam int SUM_W  = bqd_pkg::SUM_W;
    localparam int ALN_W  = bqd_pkg::ALN_W;
    localparam int FRAC_S = SAMPLE_WIDTH - bqd_pkg::SAMPLE_INT_W;
    localparam int FRAC_C = COEF_WIDTH - bqd_pkg::COEF_INT_W;
    localparam int R      = bqd_pkg::ACC_FRAC - FRAC_S;
    localparam int RND_W  = ACC_W + 1;
    localparam int YF_W   = RND_W - R;
    localparam logic [RND_W-1:0] HALF_R = RND_W'(1) << (R - 1);
    localparam logic signed [YF_W-1:0] OUT_MAX =
        {{(YF_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [YF_W-1:0] OUT_MIN =
        {{(YF_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        COEF_WIDTH'(1) << FRAC_C;

    bqd_pkg::core_state_t state_reg, state_next;

    logic signed [COEF_WIDTH-1:0] coef_reg [bqd_pkg::NUM_COEFS];
    logic signed [ACC_W-1:0]      d1_reg, d2_reg;
    logic signed [ACC_W-1:0]      y_reg;
    logic signed [YF_W-1:0]       yf_reg;
    logic signed [SUM_W-1:0]      t1_reg, t2_reg;
    logic                         m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                         clamped_reg;

    logic start_x, start_fb, load_out;
    logic done_b0, done_b1, done_b2, done_a1, done_a2;
    logic signed [ALN_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [RND_W-1:0] y_round;
    logic                    yf_over, yf_under;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_next;

    // input-side products: x*b0, x*b1, x*b2
    bqd_lane #(.OP_W(SAMPLE_WIDTH), .MAG_W(SAMPLE_WIDTH), .COEF_W(COEF_WIDTH),
               .FRAC_W(FRAC_S + FRAC_C)) u_lane_b0 (
        .aclk(aclk), .aresetn(aresetn), .start(start_x), .op(s_sample_in),
        .coef(coef_reg[bqd_pkg::REG_B0]), .done(done_b0), .product(p_b0));
    bqd_lane #(.OP_W(SAMPLE_WIDTH), .MAG_W(SAMPLE_WIDTH), .COEF_W(COEF_WIDTH),
               .FRAC_W(FRAC_S + FRAC_C)) u_lane_b1 (
        .aclk(aclk), .aresetn(aresetn), .start(start_x), .op(s_sample_in),
        .coef(coef_reg[bqd_pkg::REG_B1]), .done(done_b1), .product(p_b1));
    bqd_lane #(.OP_W(SAMPLE_WIDTH), .MAG_W(SAMPLE_WIDTH), .COEF_W(COEF_WIDTH),
               .FRAC_W(FRAC_S + FRAC_C)) u_lane_b2 (
        .aclk(aclk), .aresetn(aresetn), .start(start_x), .op(s_sample_in),
        .coef(coef_reg[bqd_pkg::REG_B2]), .done(done_b2), .product(p_b2));

    // feedback products: yf*a1, yf*a2 (|yf| stays below 2^(YF_W-2)+1)
    bqd_lane #(.OP_W(YF_W), .MAG_W(YF_W - 1), .COEF_W(COEF_WIDTH),
               .FRAC_W(FRAC_S + FRAC_C)) u_lane_a1 (
        .aclk(aclk), .aresetn(aresetn), .start(start_fb), .op(yf_reg),
        .coef(coef_reg[bqd_pkg::REG_A1]), .done(done_a1), .product(p_a1));
    bqd_lane #(.OP_W(YF_W), .MAG_W(YF_W - 1), .COEF_W(COEF_WIDTH),
               .FRAC_W(FRAC_S + FRAC_C)) u_lane_a2 (
        .aclk(aclk), .aresetn(aresetn), .start(start_fb), .op(yf_reg),
        .coef(coef_reg[bqd_pkg::REG_A2]), .done(done_a2), .product(p_a2));

    // round y to sample precision, half toward +inf
    assign y_round = RND_W'(y_reg) + signed'(HALF_R);

    // output clamp
    assign yf_over  = yf_reg > OUT_MAX;
    assign yf_under = yf_reg < OUT_MIN;
    assign sample_out_next = yf_over  ? OUT_MAX[SAMPLE_WIDTH-1:0] :
                             yf_under ? OUT_MIN[SAMPLE_WIDTH-1:0] :
                                        yf_reg[SAMPLE_WIDTH-1:0];

    // sequencer
    always_comb begin
        state_next = state_reg;
        start_x    = 1'b0;
        start_fb   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            bqd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    start_x    = 1'b1;
                    state_next = bqd_pkg::ST_MUL_X;
                end
            end
            bqd_pkg::ST_MUL_X: begin
                if (done_b0 && done_b1 && done_b2) begin
                    state_next = bqd_pkg::ST_SUM_Y;
                end
            end
            bqd_pkg::ST_SUM_Y: begin
                state_next = bqd_pkg::ST_ROUND;
            end
            bqd_pkg::ST_ROUND: begin
                state_next = bqd_pkg::ST_EMIT;
            end
            bqd_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    start_fb   = 1'b1;
                    state_next = bqd_pkg::ST_MUL_FB;
                end
            end
            bqd_pkg::ST_MUL_FB: begin
                if (done_a1 && done_a2) begin
                    state_next = bqd_pkg::ST_DIFF;
                end
            end
            bqd_pkg::ST_DIFF: begin
                state_next = bqd_pkg::ST_UPDATE;
            end
            bqd_pkg::ST_UPDATE: begin
                state_next = bqd_pkg::ST_IDLE;
            end
            default: begin
                state_next = bqd_pkg::ST_IDLE;
            end
        endcase
    end

    // control, delay state and coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bqd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            d1_reg      <= '0;
            d2_reg      <= '0;
            coef_reg[bqd_pkg::REG_B0] <= COEF_ONE;
            coef_reg[bqd_pkg::REG_B1] <= '0;
            coef_reg[bqd_pkg::REG_B2] <= '0;
            coef_reg[bqd_pkg::REG_A1] <= '0;
            coef_reg[bqd_pkg::REG_A2] <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == bqd_pkg::ST_UPDATE) begin
                d1_reg <= bqd_pkg::sat_acc(t1_reg + SUM_W'(d2_reg));
                d2_reg <= bqd_pkg::sat_acc(t2_reg);
            end
            // coefficient writes; unknown indexes are dropped
            if (cfg_valid) begin
                case (bqd_pkg::coef_idx_t'(cfg_index))
                    bqd_pkg::REG_B0: coef_reg[bqd_pkg::REG_B0] <= signed'(cfg_data);
                    bqd_pkg::REG_B1: coef_reg[bqd_pkg::REG_B1] <= signed'(cfg_data);
                    bqd_pkg::REG_B2: coef_reg[bqd_pkg::REG_B2] <= signed'(cfg_data);
                    bqd_pkg::REG_A1: coef_reg[bqd_pkg::REG_A1] <= signed'(cfg_data);
                    bqd_pkg::REG_A2: coef_reg[bqd_pkg::REG_A2] <= signed'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // datapath words
    always_ff @(posedge aclk) begin
        if (state_reg == bqd_pkg::ST_SUM_Y) begin
            y_reg <= bqd_pkg::sat_acc(SUM_W'(p_b0) + SUM_W'(d1_reg));
        end
        if (state_reg == bqd_pkg::ST_ROUND) begin
            yf_reg <= y_round[RND_W-1:R];
        end
        if (state_reg == bqd_pkg::ST_DIFF) begin
            t1_reg <= SUM_W'(p_b1) - SUM_W'(p_a1);
            t2_reg <= SUM_W'(p_b2) - SUM_W'(p_a2);
        end
        if (load_out) begin
            sample_out_reg <= sample_out_next;
            clamped_reg    <= yf_over || yf_under;
        end
    end

    assign s_ready      = (state_reg == bqd_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = sample_out_reg;
    assign m_clamped    = clamped_reg;
    assign cfg_ready    = 1'b1;

endmodule

// ===== design/bqd_checker.sv =====
// Port-level checks for biquad_df2t_section_core, attached by bind.
// Depends only on bqd_pkg and the top level's ports.
module bqd_checker #(
    parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    input logic                           m_clamped
);

    localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_clamped))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // a clamped result sits on a rail
    a_clamp_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clamped |-> (m_sample_out == OUT_MAX) || (m_sample_out == OUT_MIN))
        else $error("clamped flag without a rail value");

    // a new result appears only while a word is in progress
    a_result_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready)
        else $error("result appeared while idle");

endmodule

bind biquad_df2t_section_core bqd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqd_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_sample_out(m_sample_out),
    .m_clamped(m_clamped)
);

// ===== dv/biquad_df2t_section_core_tb.sv =====
// Self-checking bench for biquad_df2t_section_core: directed table plus random phases,
// every result word checked against a table value or an in-bench fixed-point filter model.
// Depends on bqd_pkg and the core RTL only.
`timescale 1ns / 1ps

module biquad_df2t_section_core_tb;

    localparam int SW = bqd_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW = bqd_pkg::COEF_WIDTH_DEF;

    typedef logic signed [SW-1:0]  sample_t;
    typedef logic signed [CW-1:0]  coef_t;
    typedef logic [bqd_pkg::CFG_IDX_W-1:0] reg_idx_t;
    typedef logic signed [127:0]   wide_t;

    localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam coef_t   C_ONE = coef_t'(1) <<< (CW - bqd_pkg::COEF_INT_W);
    localparam coef_t   C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coef_t   C_MIN = {1'b1, {(CW-1){1'b0}}};

    // Product alignment and output rounding shifts (Q4.F x Q6.G -> Q10.46 -> Q4.F)
    localparam int ALIGN_SH = (SW - bqd_pkg::SAMPLE_INT_W) + (CW - bqd_pkg::COEF_INT_W)
                            - bqd_pkg::ACC_FRAC;
    localparam int ROUND_SH = bqd_pkg::ACC_FRAC - (SW - bqd_pkg::SAMPLE_INT_W);

    localparam int NCOEF = bqd_pkg::NUM_COEFS;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 100;

    typedef struct packed {
        sample_t sample_out;
        logic    clamped;
    } filt_word_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CHECKED
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        reg_idx_t   idx;
        coef_t      data;
        sample_t    x;
        sample_t    want_y;
        logic       want_clamp;
    } dir_row_t;

    typedef enum int {
        COEFS_GENTLE,
        COEFS_WILD,
        COEFS_EDGE
    } coef_style_t;

    localparam int DIR_N = 33;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // bypass after reset: output equals input
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(0),  sample_t'(0),  1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, S_MAX,         S_MAX,         1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, S_MIN,         S_MIN,         1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(1),  sample_t'(1),  1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(-1), sample_t'(-1), 1'b0},
        // largest gain clamps both ways
        '{ROW_WRITE,   bqd_pkg::REG_B0, C_MAX, '0, '0, 1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(24'sh10_0000), S_MAX, 1'b1},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(-24'sh10_0000), S_MIN, 1'b1},
        // gain 2: exactly +8 is not representable, exactly -8 is
        '{ROW_WRITE,   bqd_pkg::REG_B0, coef_t'(32'h0800_0000), '0, '0, 1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(24'sh40_0000), S_MAX, 1'b1},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, sample_t'(-24'sh40_0000), S_MIN, 1'b0},
        // most negative gain
        '{ROW_WRITE,   bqd_pkg::REG_B0, C_MIN, '0, '0, 1'b0},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, S_MIN, S_MAX, 1'b1},
        '{ROW_CHECKED, bqd_pkg::REG_B0, '0, S_MAX, S_MIN, 1'b1},
        // extreme feedback drives the delay accumulators into saturation
        '{ROW_WRITE,   bqd_pkg::REG_B0, C_ONE, '0, '0, 1'b0},
        '{ROW_WRITE,   bqd_pkg::REG_B1, C_MAX, '0, '0, 1'b0},
        '{ROW_WRITE,   bqd_pkg::REG_B2, C_MAX, '0, '0, 1'b0},
        '{ROW_WRITE,   bqd_pkg::REG_A1, C_MIN, '0, '0, 1'b0},
        '{ROW_WRITE,   bqd_pkg::REG_A2, C_MIN, '0, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, S_MAX, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, S_MAX, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, S_MIN, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, S_MIN, '0, 1'b0},
        // writes to unused indexes must not disturb the coefficients
        '{ROW_WRITE,   reg_idx_t'(NCOEF),     coef_t'(32'hFFFF_FFFF), '0, '0, 1'b0},
        '{ROW_WRITE,   reg_idx_t'(NCOEF + 1), coef_t'(0),             '0, '0, 1'b0},
        '{ROW_WRITE,   reg_idx_t'(NCOEF + 2), coef_t'(32'h1234_5678), '0, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, sample_t'(0), '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, sample_t'(24'sh00_3039), '0, 1'b0},
        // positive feedback extremes saturate the other way
        '{ROW_WRITE,   bqd_pkg::REG_A1, C_MAX, '0, '0, 1'b0},
        '{ROW_WRITE,   bqd_pkg::REG_A2, C_MAX, '0, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, S_MAX, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, S_MIN, '0, 1'b0},
        '{ROW_SAMPLE,  bqd_pkg::REG_B0, '0, sample_t'(-1), '0, 1'b0}
    };

    localparam int SEND_IDLE  [PHASES] = '{0, 70, 0, 38, 0, 38};
    localparam int RECV_STALL [PHASES] = '{0, 0, 70, 38, 0, 38};
    localparam int PRESSURE_PHASE = 4;

    // DUT ports
    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    sample_t s_sample_in = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    sample_t m_sample_out;
    logic    m_clamped;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    reg_idx_t cfg_index = '0;
    coef_t   cfg_data = '0;

    // Filter model state
    coef_t   coef_q [NCOEF];
    wide_t   z1_acc;
    wide_t   z2_acc;

    filt_word_t expected_words [$];
    int      fail_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_asked = 0;
    int      hold_served;
    int      hold_left;
    int      quiet_cycles;
    bit      words_since_settle = 1'b0;

    biquad_df2t_section_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clamped    (m_clamped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Exact product aligned to Q.46, half away from zero, magnitude capped at 2^62
    function automatic wide_t q46_product(input wide_t a, input wide_t c);
        wide_t mag;
        logic  neg;
        int    sh;
        sh  = ALIGN_SH;
        neg = (a < 0) != (c < 0);
        mag = (a < 0 ? -a : a) * (c < 0 ? -c : c);
        if (sh > 0) begin
            mag = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
        end else if (sh < 0) begin
            mag = mag <<< (-sh);
        end
        if (mag > (wide_t'(1) <<< 62)) begin
            mag = wide_t'(1) <<< 62;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic wide_t sat_q46(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (bqd_pkg::ACC_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // One sample through the section: output word, then delay update with unclamped y
    function automatic filt_word_t filter_step(input sample_t x_in);
        wide_t      x;
        wide_t      y;
        wide_t      yr;
        filt_word_t w;
        x  = wide_t'(x_in);
        y  = sat_q46(q46_product(x, wide_t'(coef_q[bqd_pkg::REG_B0])) + z1_acc);
        yr = (y + (wide_t'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        z1_acc = sat_q46(q46_product(x, wide_t'(coef_q[bqd_pkg::REG_B1]))
                         - q46_product(yr, wide_t'(coef_q[bqd_pkg::REG_A1])) + z2_acc);
        z2_acc = sat_q46(q46_product(x, wide_t'(coef_q[bqd_pkg::REG_B2]))
                         - q46_product(yr, wide_t'(coef_q[bqd_pkg::REG_A2])));
        if (yr > wide_t'(S_MAX)) begin
            w = '{S_MAX, 1'b1};
        end else if (yr < wide_t'(S_MIN)) begin
            w = '{S_MIN, 1'b1};
        end else begin
            w = '{yr[SW-1:0], 1'b0};
        end
        return w;
    endfunction

    function automatic coef_t pick_coef(input coef_style_t style, input reg_idx_t idx);
        int lim;
        case (style)
            COEFS_GENTLE: begin
                // roughly stable sections: |b| <= 1, |a1| < 1.9, |a2| < 0.9
                if (idx == bqd_pkg::REG_A1) begin
                    lim = 127506841;
                end else if (idx == bqd_pkg::REG_A2) begin
                    lim = 60397977;
                end else begin
                    lim = 1 << (CW - bqd_pkg::COEF_INT_W);
                end
                return coef_t'(int'($urandom_range(2 * lim)) - lim);
            end
            COEFS_EDGE: begin
                case ($urandom_range(4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    3: return C_ONE;
                    default: return -C_ONE;
                endcase
            end
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return sample_t'($urandom);
            5, 6, 7: return sample_t'(int'($urandom_range(1 << 21)) - (1 << 20));
            default: begin
                case ($urandom_range(4))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return '0;
                    3: return sample_t'(1);
                    default: return sample_t'(-1);
                endcase
            end
        endcase
    endfunction

    // Wait until every expected word is back and the section has finished its update
    task automatic settle();
        if (words_since_settle) begin
            s_valid <= 1'b0;
            while (expected_words.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            words_since_settle = 1'b0;
        end
    endtask

    task automatic write_coef(input reg_idx_t idx, input coef_t data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < NCOEF) begin
            coef_q[idx] = data;
        end
    endtask

    // Offer one sample word; valid is left high so a back-to-back word needs no gap
    task automatic send_sample(input sample_t x, input bit typed, input filt_word_t typed_word);
        filt_word_t w;
        if (cfg_valid) begin
            cfg_valid <= 1'b0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        w = filter_step(x);
        expected_words.push_back(typed ? typed_word : w);
        words_since_settle = 1'b1;
    endtask

    // Result checker
    always @(posedge aclk) begin : check_words
        filt_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: sample_out %0d clamped %0b", m_sample_out, m_clamped);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_sample_out !== want.sample_out) begin
                    $error("sample_out: expected %0d, got %0d", want.sample_out, m_sample_out);
                    fail_count++;
                end
                if (m_clamped !== want.clamped) begin
                    $error("clamped: expected %0b, got %0b", want.clamped, m_clamped);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_served <= 0;
            hold_left   <= 0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("biquad_df2t_section_core_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          i;
        int          phase;
        coef_style_t style;
        reg_idx_t    k;

        // model matches the reset state: bypass coefficients, empty delays
        for (i = 0; i < NCOEF; i++) begin
            coef_q[i] = '0;
        end
        coef_q[bqd_pkg::REG_B0] = C_ONE;
        z1_acc = '0;
        z2_acc = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (i = 0; i < DIR_N; i++) begin
            case (DIR_ROWS[i].kind)
                ROW_WRITE: write_coef(DIR_ROWS[i].idx, DIR_ROWS[i].data);
                ROW_CHECKED: send_sample(DIR_ROWS[i].x, 1'b1,
                                         '{DIR_ROWS[i].want_y, DIR_ROWS[i].want_clamp});
                default: send_sample(DIR_ROWS[i].x, 1'b0, '0);
            endcase
        end

        // random phases, each with its own coefficient set and handshake pacing
        for (phase = 0; phase < PHASES; phase++) begin
            style = coef_style_t'(phase % 3);
            for (i = 0; i < NCOEF; i++) begin
                k = reg_idx_t'(i);
                write_coef(k, pick_coef(style, k));
            end
            if (phase % 2 == 1) begin
                write_coef(reg_idx_t'(NCOEF + $urandom_range(2)), coef_t'($urandom));
            end
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            if (phase == PRESSURE_PHASE) begin
                hold_asked++;
            end
            for (i = 0; i < PHASE_WORDS; i++) begin
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("biquad_df2t_section_core_tb: clean");
        end else begin
            $display("biquad_df2t_section_core_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bqd_pkg.sv
design/bqd_lane.sv
design/biquad_df2t_section_core.sv
design/bqd_checker.sv
dv/biquad_df2t_section_core_tb.sv
